// ===== rtl/vdft_pkg.sv =====
// vdft_pkg: shared types, codes and defaults of the vertex dedup fan triangulator
// depends on nothing; imported by every rtl file of the block
package vdft_pkg;

    localparam int CACHE_SIZE_DEF = 1024;
    localparam int INDEX_BITS_DEF = 24;
    localparam int FIELD_W        = 24;

    localparam logic [2:0] CMD_POSITION = 3'd0;
    localparam logic [2:0] CMD_TEXCOORD = 3'd1;
    localparam logic [2:0] CMD_NORMAL   = 3'd2;
    localparam logic [2:0] CMD_CORNER   = 3'd3;
    localparam logic [2:0] CMD_BOUNDARY = 3'd4;

    localparam logic [1:0] KIND_INDEX = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] SEL_PIVOT = 2'd0;
    localparam logic [1:0] SEL_PREV  = 2'd1;
    localparam logic [1:0] SEL_CUR   = 2'd2;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [FIELD_W-1:0] vertex_index;
        logic signed [FIELD_W-1:0] texcoord_index;
        logic signed [FIELD_W-1:0] normal_index;
        logic                     corner_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FIELD_W-1:0] vertex_number;
        logic [FIELD_W-1:0] draw_first;
        logic [FIELD_W-1:0] draw_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic       clear;
        logic       accept;
        logic       load_pivot;
        logic       load_tri;
        logic       emit_err;
        logic       look;
        logic [1:0] look_sel;
        logic       look_last;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/vertex_dedup_fan_triangulator.sv =====
// vertex_dedup_fan_triangulator: top level, controller plus datapath
// depends on vdft_pkg, vdft_ctrl and vdft_datapath
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// declare, boundary, short-face and first/second corner items are done at intake alone
// a fan corner takes intake with the pivot read, then the pivot, previous and current
//   lookups in turn on the single cache read port, the next read overlapping each compare
// after reset a clearing pass over every cache entry runs before the first transfer in
// a stalled output holds the lookup sequence and keeps the input not ready
module vertex_dedup_fan_triangulator #(
    parameter int CACHE_SIZE = vdft_pkg::CACHE_SIZE_DEF,
    parameter int INDEX_BITS = vdft_pkg::INDEX_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vdft_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vdft_pkg::t_out_item o_out_data
);
    import vdft_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    vdft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vdft_datapath #(
        .CACHE_SIZE (CACHE_SIZE),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/vdft_ctrl.sv =====
// vdft_ctrl: state machine for cache clear, item intake and the three fan lookups
// depends on vdft_pkg; drives vdft_datapath through t_ctl_cmd
module vdft_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  vdft_pkg::t_in_item i_in_data,
    output logic               o_in_ready,
    input  vdft_pkg::t_dp_stat i_stat,
    output vdft_pkg::t_ctl_cmd o_cmd
);
    import vdft_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    localparam logic [1:0] CORNERS_FAN = 2'd2;

    t_state     r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic [1:0] r_corner_cnt, n_corner_cnt;
    t_ctl_cmd   cmd;
    logic       ready;
    logic       accept;

    always_comb begin
        n_state      = r_state;
        n_sel        = r_sel;
        n_corner_cnt = r_corner_cnt;
        cmd          = '0;
        ready        = 1'b0;
        accept       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ready      = i_stat.out_free;
                accept     = i_in_valid && ready;
                cmd.accept = accept;
                if (accept && i_in_data.command == CMD_CORNER) begin
                    cmd.load_pivot = (r_corner_cnt == 2'd0);
                    if (r_corner_cnt == CORNERS_FAN) begin
                        cmd.load_tri = 1'b1;
                        n_state      = S_LOOK;
                        n_sel        = SEL_PIVOT;
                    end
                    if (i_in_data.corner_last) begin
                        cmd.emit_err = (r_corner_cnt != CORNERS_FAN);
                        n_corner_cnt = 2'd0;
                    end else if (r_corner_cnt != CORNERS_FAN) begin
                        n_corner_cnt = r_corner_cnt + 2'd1;
                    end
                end
            end
            S_LOOK: begin
                cmd.look_sel  = r_sel;
                cmd.look_last = (r_sel == SEL_CUR);
                if (i_stat.out_free) begin
                    cmd.look = 1'b1;
                    if (r_sel == SEL_CUR) begin
                        n_state = S_IDLE;
                    end else begin
                        n_sel = r_sel + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_sel        <= SEL_PIVOT;
            r_corner_cnt <= 2'd0;
        end else begin
            r_state      <= n_state;
            r_sel        <= n_sel;
            r_corner_cnt <= n_corner_cnt;
        end
    end

    assign o_in_ready = ready;
    assign o_cmd      = cmd;

endmodule

// ===== rtl/vdft_datapath.sv =====
// vdft_datapath: counters, index resolve, vertex cache memory and output register
// depends on vdft_pkg; commanded by vdft_ctrl
module vdft_datapath #(
    parameter int CACHE_SIZE = vdft_pkg::CACHE_SIZE_DEF,
    parameter int INDEX_BITS = vdft_pkg::INDEX_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vdft_pkg::t_ctl_cmd  i_cmd,
    input  vdft_pkg::t_in_item  i_in_data,
    output vdft_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vdft_pkg::t_out_item o_out_data
);
    import vdft_pkg::*;

    localparam int IB = INDEX_BITS;
    localparam int AW = $clog2(CACHE_SIZE);
    localparam int EW = (IB > FIELD_W) ? IB : FIELD_W;
    localparam int HW = (IB > AW) ? IB : AW;
    localparam int MW = 1 + 4 * IB;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CACHE_SIZE - 1);

    function automatic logic [IB-1:0] f_resolve(input logic signed [FIELD_W-1:0] raw,
                                                input logic [IB-1:0] cnt);
        logic [EW-1:0] ext;
        logic [IB-1:0] v;
        ext = EW'(raw);
        v   = ext[IB-1:0];
        if (raw[FIELD_W-1]) begin
            return IB'(cnt + v + IB'(1));
        end
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] f_out(input logic [IB-1:0] val);
        logic [EW-1:0] z;
        z = EW'(val);
        return z[FIELD_W-1:0];
    endfunction

    function automatic logic [AW-1:0] f_hash(input logic [IB-1:0] k0,
                                             input logic [IB-1:0] k1,
                                             input logic [IB-1:0] k2);
        logic [HW-1:0] x;
        x = HW'(k0 ^ k1 ^ k2) & HW'(CACHE_SIZE - 1);
        return x[AW-1:0];
    endfunction

    logic [IB-1:0] r_pos_cnt, r_tex_cnt, r_norm_cnt;
    logic [IB-1:0] r_unique, r_index, r_group_first;
    logic          r_any_group;
    logic [AW-1:0] r_clr_addr;

    logic [IB-1:0] r_piv [3];
    logic [IB-1:0] r_prv [3];
    logic [IB-1:0] r_opw [3][3];
    logic [IB-1:0] c_cur [3];

    logic [MW-1:0] r_mem [CACHE_SIZE];
    logic [MW-1:0] r_rdata;
    logic [AW-1:0] r_look_addr;
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [MW-1:0] r_fwd_word;

    logic          r_out_valid;
    t_out_item     r_out, n_out;
    logic          emit;
    logic          out_free;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [MW-1:0] look_word;
    logic [IB-1:0] look_key [3];
    logic [IB-1:0] next_key [3];
    logic          hit;
    logic [IB-1:0] look_vn;
    logic          is_corner, is_boundary, draw_ok;

    assign c_cur[0] = f_resolve(i_in_data.vertex_index, r_pos_cnt);
    assign c_cur[1] = f_resolve(i_in_data.texcoord_index, r_tex_cnt);
    assign c_cur[2] = f_resolve(i_in_data.normal_index, r_norm_cnt);

    assign is_corner   = i_cmd.accept && (i_in_data.command == CMD_CORNER);
    assign is_boundary = i_cmd.accept && (i_in_data.command == CMD_BOUNDARY);
    assign draw_ok     = r_any_group || (r_index != '0);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            case (i_cmd.look_sel)
                SEL_PIVOT: begin
                    look_key[p] = r_opw[0][p];
                    next_key[p] = r_opw[1][p];
                end
                SEL_PREV: begin
                    look_key[p] = r_opw[1][p];
                    next_key[p] = r_opw[2][p];
                end
                default: begin
                    look_key[p] = r_opw[2][p];
                    next_key[p] = r_opw[2][p];
                end
            endcase
        end
    end

    // cache read: pivot at intake, then the next operand while the current one compares
    assign rd_en   = i_cmd.load_tri || (i_cmd.look && !i_cmd.look_last);
    assign rd_addr = i_cmd.load_tri ? f_hash(r_piv[0], r_piv[1], r_piv[2])
                                    : f_hash(next_key[0], next_key[1], next_key[2]);

    // write of the previous lookup is not yet visible on the read port
    assign look_word = (r_fwd_valid && r_fwd_addr == r_look_addr) ? r_fwd_word : r_rdata;

    always_comb begin
        hit = look_word[MW-1]
              && look_word[4*IB-1:3*IB] == look_key[0]
              && look_word[3*IB-1:2*IB] == look_key[1]
              && look_word[2*IB-1:IB]   == look_key[2];
        look_vn = hit ? look_word[IB-1:0] : r_unique;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_look_addr;
        mem_wdata = {1'b1, look_key[0], look_key[1], look_key[2], r_unique};
        if (i_cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.look && !hit) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        emit  = 1'b0;
        n_out = '0;
        if (i_cmd.look) begin
            emit                = 1'b1;
            n_out.kind          = KIND_INDEX;
            n_out.vertex_number = f_out(look_vn);
            n_out.last          = i_cmd.look_last;
        end else if (is_corner && i_cmd.emit_err) begin
            emit       = 1'b1;
            n_out.kind = KIND_ERROR;
            n_out.last = 1'b1;
        end else if (is_boundary && draw_ok) begin
            emit             = 1'b1;
            n_out.kind       = KIND_DRAW;
            n_out.draw_first = f_out(r_group_first);
            n_out.draw_count = f_out(IB'(r_index - r_group_first));
            n_out.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_cnt     <= '0;
            r_tex_cnt     <= '0;
            r_norm_cnt    <= '0;
            r_unique      <= '0;
            r_index       <= '0;
            r_group_first <= '0;
            r_any_group   <= 1'b0;
            r_clr_addr    <= '0;
            r_fwd_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.accept && i_in_data.command == CMD_POSITION) begin
                r_pos_cnt <= r_pos_cnt + IB'(1);
            end
            if (i_cmd.accept && i_in_data.command == CMD_TEXCOORD) begin
                r_tex_cnt <= r_tex_cnt + IB'(1);
            end
            if (i_cmd.accept && i_in_data.command == CMD_NORMAL) begin
                r_norm_cnt <= r_norm_cnt + IB'(1);
            end
            if (is_boundary && draw_ok) begin
                r_group_first <= r_index;
                r_any_group   <= 1'b1;
            end
            if (i_cmd.look) begin
                r_index <= r_index + IB'(1);
                if (!hit) begin
                    r_unique    <= r_unique + IB'(1);
                    r_fwd_valid <= 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_corner) begin
            for (int p = 0; p < 3; p++) begin
                r_prv[p] <= c_cur[p];
                if (i_cmd.load_pivot) begin
                    r_piv[p] <= c_cur[p];
                end
                if (i_cmd.load_tri) begin
                    r_opw[0][p] <= r_piv[p];
                    r_opw[1][p] <= r_prv[p];
                    r_opw[2][p] <= c_cur[p];
                end
            end
        end
        if (rd_en) begin
            r_look_addr <= rd_addr;
        end
        if (i_cmd.look && !hit) begin
            r_fwd_addr <= r_look_addr;
            r_fwd_word <= mem_wdata;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_stat.clear_done = (r_clr_addr == LAST_ADDR);
    assign o_stat.out_free   = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ===== rtl/vdft_checker.sv =====
// vdft_checker: port-level assertions for vertex_dedup_fan_triangulator
// depends on vdft_pkg; attached to the top level by the bind below
module vdft_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input vdft_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input vdft_pkg::t_out_item o_out_data
);
    import vdft_pkg::*;

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transfer changed");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_INDEX |-> o_out_data.last)
        else $error("draw or error result without last");

    a_declare_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.command == CMD_POSITION ||
        i_in_data.command == CMD_TEXCOORD || i_in_data.command == CMD_NORMAL)
        |=> !o_out_valid)
        else $error("declare transfer produced a result");

endmodule

bind vertex_dedup_fan_triangulator vdft_checker u_chk (.*);

// ===== tb/tb_vertex_dedup_fan_triangulator.sv =====
// testbench of vertex_dedup_fan_triangulator: directed and random mesh events
// checked against an in-bench fan/vertex-cache predictor; needs vdft_pkg and the rtl
module tb_vertex_dedup_fan_triangulator;
    timeunit 1ns;
    timeprecision 1ps;

    import vdft_pkg::*;

    localparam int VC_DEPTH       = CACHE_SIZE_DEF;
    localparam int VC_BITS        = $clog2(VC_DEPTH);
    localparam int N_RANDOM       = 320;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_REPORTS    = 40;

    typedef logic [FIELD_W-1:0] t_idx;
    typedef struct packed {
        t_idx p;
        t_idx t;
        t_idx n;
    } t_corner;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    vertex_dedup_fan_triangulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // predictor state
    bit        vc_valid [VC_DEPTH];
    t_corner   vc_key   [VC_DEPTH];
    t_idx      vc_num   [VC_DEPTH];
    t_idx      pos_cnt, tex_cnt, nrm_cnt;
    t_idx      unique_cnt, index_cnt, group_first;
    int        corner_cnt;
    t_corner   pivot, prev;
    bit        group_seen;

    t_out_item due_records [$];
    t_in_item  stim_q [$];

    int n_total = 1_000_000;
    int n_in_acc = 0;
    int n_out_acc = 0;
    int n_err = 0;
    int n_index = 0;
    int n_draw = 0;
    int n_fault = 0;
    int stall_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    bit quiet;

    assign quiet = (n_in_acc + 40 >= n_total);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_idx resolve_idx(logic signed [FIELD_W-1:0] raw, t_idx cnt);
        if (raw[FIELD_W-1])
            return cnt + t_idx'(raw) + t_idx'(1);
        return t_idx'(raw);
    endfunction

    function automatic t_idx cache_lookup(t_corner c);
        logic [VC_BITS-1:0] h;
        t_idx               vn;
        h = VC_BITS'(c.p ^ c.t ^ c.n);
        if (vc_valid[h] && vc_key[h] == c) begin
            vn = vc_num[h];
        end else begin
            vn          = unique_cnt;
            unique_cnt  = unique_cnt + t_idx'(1);
            vc_valid[h] = 1'b1;
            vc_key[h]   = c;
            vc_num[h]   = vn;
        end
        index_cnt = index_cnt + t_idx'(1);
        return vn;
    endfunction

    function automatic void triangulate_item(t_in_item it);
        t_out_item res [3];
        int        n;
        t_corner   cur;
        n = 0;
        for (int i = 0; i < 3; i++) begin
            res[i]      = '0;
            res[i].kind = KIND_INDEX;
        end
        case (it.command)
            CMD_POSITION: pos_cnt = pos_cnt + t_idx'(1);
            CMD_TEXCOORD: tex_cnt = tex_cnt + t_idx'(1);
            CMD_NORMAL:   nrm_cnt = nrm_cnt + t_idx'(1);
            CMD_CORNER: begin
                cur.p = resolve_idx(it.vertex_index, pos_cnt);
                cur.t = resolve_idx(it.texcoord_index, tex_cnt);
                cur.n = resolve_idx(it.normal_index, nrm_cnt);
                if (corner_cnt == 0) begin
                    pivot = cur;
                end else if (corner_cnt >= 2) begin
                    res[0].vertex_number = cache_lookup(pivot);
                    res[1].vertex_number = cache_lookup(prev);
                    res[2].vertex_number = cache_lookup(cur);
                    n = 3;
                end
                prev = cur;
                if (it.corner_last) begin
                    if (corner_cnt < 2) begin
                        res[0].kind = KIND_ERROR;
                        n = 1;
                    end
                    corner_cnt = 0;
                end else if (corner_cnt < 2) begin
                    corner_cnt++;
                end
            end
            CMD_BOUNDARY: begin
                if (group_seen || index_cnt != 0) begin
                    res[0].kind       = KIND_DRAW;
                    res[0].draw_first = group_first;
                    res[0].draw_count = index_cnt - group_first;
                    n = 1;
                    group_first = index_cnt;
                    group_seen  = 1'b1;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            due_records = {due_records, res[i]};
        end
    endfunction

    function automatic void compare_field(string name, logic [FIELD_W-1:0] want,
                                          logic [FIELD_W-1:0] got);
        if (got !== want) begin
            if (n_err < MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            n_err++;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (stim_q.size() > 0) begin
                i_in_data  <= stim_q.pop_front();
                i_in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    in_gap <= $urandom_range(1, 10);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && n_in_acc >= 80) begin
            hold_cnt    <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0 && !quiet) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            out_gap     <= 0;
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                out_gap <= $urandom_range(1, 10);
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_out_item want;
        bit        in_xfer;
        bit        out_xfer;
        in_xfer  = i_rst_n && i_in_valid && o_in_ready;
        out_xfer = i_rst_n && o_out_valid && i_out_ready;
        if (in_xfer) begin
            triangulate_item(i_in_data);
            n_in_acc <= n_in_acc + 1;
        end
        if (out_xfer) begin
            n_out_acc <= n_out_acc + 1;
            if (due_records.size() == 0) begin
                if (n_err < MAX_REPORTS)
                    $display("%0t: no result expected, actual %p", $time, o_out_data);
                n_err++;
            end else begin
                want = due_records.pop_front();
                case (want.kind)
                    KIND_INDEX: n_index++;
                    KIND_DRAW:  n_draw++;
                    default:    n_fault++;
                endcase
                compare_field("kind", FIELD_W'(want.kind), FIELD_W'(o_out_data.kind));
                compare_field("vertex_number", want.vertex_number, o_out_data.vertex_number);
                compare_field("draw_first", want.draw_first, o_out_data.draw_first);
                compare_field("draw_count", want.draw_count, o_out_data.draw_count);
                compare_field("last", FIELD_W'(want.last), FIELD_W'(o_out_data.last));
            end
        end
        if (in_xfer || out_xfer)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, due_records.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [2:0] cmd, int v, int t, int n, bit lst);
        t_in_item it;
        it.command        = cmd;
        it.vertex_index   = v[FIELD_W-1:0];
        it.texcoord_index = t[FIELD_W-1:0];
        it.normal_index   = n[FIELD_W-1:0];
        it.corner_last    = lst;
        return it;
    endfunction

    function automatic void stim_add(t_in_item it);
        stim_q = {stim_q, it};
    endfunction

    function automatic int pick_index();
        case ($urandom_range(0, 9))
            0:       return 0;
            1, 2:    return -int'($urandom_range(1, 6));
            3:       return int'($urandom);
            default: return int'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic t_in_item rand_corner(bit lst);
        return make_item(CMD_CORNER, pick_index(), pick_index(), pick_index(), lst);
    endfunction

    function automatic t_in_item rand_other(logic [2:0] cmd);
        return make_item(cmd, int'($urandom), int'($urandom), int'($urandom),
                         1'($urandom));
    endfunction

    task automatic corr_init();
        pos_cnt     = '0;
        tex_cnt     = '0;
        nrm_cnt     = '0;
        unique_cnt  = '0;
        index_cnt   = '0;
        group_first = '0;
        corner_cnt  = 0;
        pivot       = '0;
        prev        = '0;
        group_seen  = 1'b0;
        for (int i = 0; i < VC_DEPTH; i++)
            vc_valid[i] = 1'b0;
    endtask

    initial begin
        int n_rand;
        int r;
        int nc;
        corr_init();

        // boundary with nothing emitted, unused codes, short faces
        stim_add(make_item(CMD_BOUNDARY, 0, 0, 0, 1'b0));
        stim_add(make_item(3'd5, -1, -1, -1, 1'b1));
        stim_add(make_item(3'd6, 0, 0, 0, 1'b0));
        stim_add(make_item(3'd7, 8388607, -8388608, 1, 1'b1));
        stim_add(make_item(CMD_CORNER, 1, 0, 0, 1'b1));
        stim_add(make_item(CMD_CORNER, 2, 0, 0, 1'b0));
        stim_add(make_item(CMD_CORNER, 3, 0, 0, 1'b1));
        stim_add(make_item(CMD_BOUNDARY, 0, 0, 0, 1'b1));
        for (int i = 0; i < 3; i++)
            stim_add(make_item(CMD_POSITION, -1, -1, -1, 1'b1));
        stim_add(make_item(CMD_TEXCOORD, 0, 0, 0, 1'b0));
        stim_add(make_item(CMD_TEXCOORD, 0, 0, 0, 1'b0));
        stim_add(make_item(CMD_NORMAL, 0, 0, 0, 1'b0));
        // fan with a boundary and a declare inside the face
        stim_add(make_item(CMD_CORNER, 1, 1, 1, 1'b0));
        stim_add(make_item(CMD_CORNER, 2, -1, 0, 1'b0));
        stim_add(make_item(CMD_BOUNDARY, 0, 0, 0, 1'b0));
        stim_add(make_item(CMD_CORNER, 3, 0, -2, 1'b0));
        stim_add(make_item(CMD_POSITION, 0, 0, 0, 1'b0));
        stim_add(make_item(CMD_CORNER, -1, 8388607, -8388608, 1'b1));
        stim_add(make_item(CMD_BOUNDARY, 0, 0, 0, 1'b0));
        stim_add(make_item(CMD_BOUNDARY, 0, 0, 0, 1'b0));
        // extremes and relative indices below the first element
        stim_add(make_item(CMD_CORNER, 8388607, -8388608, 0, 1'b0));
        stim_add(make_item(CMD_CORNER, -8388608, 0, 8388607, 1'b0));
        stim_add(make_item(CMD_CORNER, 8388607, -8388608, 0, 1'b1));
        stim_add(make_item(CMD_BOUNDARY, -1, -1, -1, 1'b1));

        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                stim_add(rand_other(3'($urandom_range(0, 2))));
                n_rand++;
            end else if (r < 13) begin
                stim_add(rand_other(CMD_BOUNDARY));
                n_rand++;
            end else if (r < 15) begin
                stim_add(rand_other(3'($urandom_range(5, 7))));
            end else if (r < 18) begin
                nc = $urandom_range(1, 2);
                for (int i = 0; i < nc; i++)
                    stim_add(rand_corner(i == nc - 1));
                n_rand += nc;
            end else if (r < 21) begin
                stim_add(rand_corner(1'($urandom)));
                n_rand++;
            end else begin
                nc = $urandom_range(3, 6);
                for (int i = 0; i < nc; i++) begin
                    if (i > 0 && $urandom_range(0, 9) == 0) begin
                        stim_add(rand_other(3'($urandom_range(0, 4) == 4 ?
                                 CMD_BOUNDARY : $urandom_range(0, 2))));
                        n_rand++;
                    end
                    stim_add(rand_corner(i == nc - 1));
                    n_rand++;
                end
            end
        end
        n_total = stim_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (stim_q.size() != 0 || i_in_valid || due_records.size() != 0);
        repeat (20) @(posedge i_clk);

        $display("covered %0d input transfers, %0d results: %0d indices, %0d draw records,",
                 n_in_acc, n_out_acc, n_index, n_draw);
        $display("  %0d face errors, %0d unique vertices, one long output hold-off",
                 n_fault, unique_cnt);
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
